### rtl/core/vrp_pkg.sv
// ----------------------------------------------------------------------------
// vrp_pkg
// shared widths, register map and beat types of the vertex rotate/project unit
// ----------------------------------------------------------------------------
package vrp_pkg;

  // field widths
  localparam int unsigned CoordW   = 24;  // vertex coordinate, q15.8
  localparam int unsigned TrigW    = 18;  // sine/cosine, q1.16
  localparam int unsigned SizeW    = 13;  // screen size in pixels
  localparam int unsigned ScrW     = 16;  // screen coordinate
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 18;

  // fraction bits of the trig values
  localparam int unsigned TrigFrac = 16;

  // internal widths
  localparam int unsigned ProdW  = CoordW + TrigW;       // coord * trig
  localparam int unsigned RotW   = ProdW + 1;            // after x rotation
  localparam int unsigned SplitW = 22;                   // low slice of RotW words
  localparam int unsigned HiPW   = RotW - SplitW + TrigW;
  localparam int unsigned LoPW   = SplitW + 1 + TrigW;
  localparam int unsigned YzW    = RotW + TrigW;         // y1*sz, y1*cz, z1*sy
  localparam int unsigned X2W    = YzW + 1;              // after y rotation
  localparam int unsigned ChunkW = 21;                   // slices of x2
  localparam int unsigned TopCW  = X2W - 2 * ChunkW;
  localparam int unsigned LoP2W  = ChunkW + 1 + TrigW;
  localparam int unsigned HiP2W  = TopCW + TrigW;
  localparam int unsigned MidW   = HiP2W + ChunkW + 2;
  localparam int unsigned FinW   = 82;                   // scale 2^56 values
  localparam int unsigned MagW   = FinW + 1;             // magnitude plus half
  localparam int unsigned FinalShift = 56;
  localparam int unsigned HiW    = MagW - FinalShift;

  // saturation limits
  localparam logic [ScrW-1:0] ScrMax = 16'h7fff;
  localparam logic [ScrW-1:0] ScrMin = 16'h8000;

  // reset values
  localparam logic [TrigW-1:0] SinReset    = 18'h00000;
  localparam logic [TrigW-1:0] CosReset    = 18'h10000;
  localparam logic [SizeW-1:0] WidthReset  = 13'd900;
  localparam logic [SizeW-1:0] HeightReset = 13'd700;

  typedef enum logic [CfgIdxW-1:0] {
    CfgSinX         = 3'd0,
    CfgCosX         = 3'd1,
    CfgSinY         = 3'd2,
    CfgCosY         = 3'd3,
    CfgSinZ         = 3'd4,
    CfgCosZ         = 3'd5,
    CfgScreenWidth  = 3'd6,
    CfgScreenHeight = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [TrigW-1:0] sin_x;
    logic [TrigW-1:0] cos_x;
    logic [TrigW-1:0] sin_y;
    logic [TrigW-1:0] cos_y;
    logic [TrigW-1:0] sin_z;
    logic [TrigW-1:0] cos_z;
    logic [SizeW-1:0] screen_width;
    logic [SizeW-1:0] screen_height;
  } cfg_t;

  typedef struct packed {
    logic [ScrW-1:0] screen_x;
    logic [ScrW-1:0] screen_y;
    logic            clipped;
  } pix_t;

endpackage

### rtl/core/vrp_rot_x.sv
// ----------------------------------------------------------------------------
// vrp_rot_x
// rotation about x, plus the x*cos_y product needed by the y rotation
// ----------------------------------------------------------------------------
module vrp_rot_x (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     en_i,
  input  vrp_pkg::cfg_t                            cfg_i,
  input  logic                                     valid_i,
  input  logic signed [vrp_pkg::CoordW-1:0]        vert_x_i,
  input  logic signed [vrp_pkg::CoordW-1:0]        vert_y_i,
  input  logic signed [vrp_pkg::CoordW-1:0]        vert_z_i,
  output logic                                     valid_o,
  output logic signed [vrp_pkg::RotW-1:0]          y1_o,
  output logic signed [vrp_pkg::RotW-1:0]          z1_o,
  output logic signed [vrp_pkg::ProdW-1:0]         xcy_o
);
  import vrp_pkg::*;

  logic signed [TrigW-1:0] sx, cx, cy;
  logic signed [ProdW-1:0] ycx_d, zsx_d, ysx_d, zcx_d, xcy_d;
  logic signed [ProdW-1:0] ycx_q, zsx_q, ysx_q, zcx_q, xcy_q;
  logic signed [RotW-1:0]  y1_d, z1_d, y1_q, z1_q;
  logic signed [ProdW-1:0] xcy2_q;
  logic                    v1_q, v2_q;

  assign sx = $signed(cfg_i.sin_x);
  assign cx = $signed(cfg_i.cos_x);
  assign cy = $signed(cfg_i.cos_y);

  // stage 1: products
  assign ycx_d = vert_y_i * cx;
  assign zsx_d = vert_z_i * sx;
  assign ysx_d = vert_y_i * sx;
  assign zcx_d = vert_z_i * cx;
  assign xcy_d = vert_x_i * cy;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ycx_q <= ycx_d;
      zsx_q <= zsx_d;
      ysx_q <= ysx_d;
      zcx_q <= zcx_d;
      xcy_q <= xcy_d;
    end
  end

  // stage 2: sums
  assign y1_d = RotW'(ycx_q) - RotW'(zsx_q);
  assign z1_d = RotW'(ysx_q) + RotW'(zcx_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      y1_q   <= y1_d;
      z1_q   <= z1_d;
      xcy2_q <= xcy_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  assign valid_o = v2_q;
  assign y1_o    = y1_q;
  assign z1_o    = z1_q;
  assign xcy_o   = xcy2_q;

endmodule

### rtl/core/vrp_rot_y.sv
// ----------------------------------------------------------------------------
// vrp_rot_y
// rotation about y, split multiplies of the wide x-rotated terms
// ----------------------------------------------------------------------------
module vrp_rot_y (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     en_i,
  input  vrp_pkg::cfg_t                            cfg_i,
  input  logic                                     valid_i,
  input  logic signed [vrp_pkg::RotW-1:0]          y1_i,
  input  logic signed [vrp_pkg::RotW-1:0]          z1_i,
  input  logic signed [vrp_pkg::ProdW-1:0]         xcy_i,
  output logic                                     valid_o,
  output logic signed [vrp_pkg::X2W-1:0]           x2_o,
  output logic signed [vrp_pkg::YzW-1:0]           y1sz_o,
  output logic signed [vrp_pkg::YzW-1:0]           y1cz_o
);
  import vrp_pkg::*;

  logic signed [TrigW-1:0]       sy, sz, cz;
  logic signed [RotW-SplitW-1:0] z1_hi, y1_hi;
  logic signed [SplitW:0]        z1_lo, y1_lo;

  logic signed [HiPW-1:0] zsy_hi_q, ysz_hi_q, ycz_hi_q;
  logic signed [LoPW-1:0] zsy_lo_q, ysz_lo_q, ycz_lo_q;
  logic signed [ProdW-1:0] xcy3_q, xcy4_q;
  logic signed [YzW-1:0]  zsy_q, ysz4_q, ycz4_q, ysz5_q, ycz5_q;
  logic signed [X2W-1:0]  x2_d, x2_q;
  logic                   v3_q, v4_q, v5_q;

  assign sy = $signed(cfg_i.sin_y);
  assign sz = $signed(cfg_i.sin_z);
  assign cz = $signed(cfg_i.cos_z);

  // signed high slice, unsigned low slice
  assign z1_hi = z1_i[RotW-1:SplitW];
  assign y1_hi = y1_i[RotW-1:SplitW];
  assign z1_lo = {1'b0, z1_i[SplitW-1:0]};
  assign y1_lo = {1'b0, y1_i[SplitW-1:0]};

  // stage 3: partial products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      zsy_hi_q <= z1_hi * sy;
      zsy_lo_q <= z1_lo * sy;
      ysz_hi_q <= y1_hi * sz;
      ysz_lo_q <= y1_lo * sz;
      ycz_hi_q <= y1_hi * cz;
      ycz_lo_q <= y1_lo * cz;
      xcy3_q   <= xcy_i;
    end
  end

  // stage 4: recombine slices
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      zsy_q  <= (YzW'(zsy_hi_q) <<< SplitW) + YzW'(zsy_lo_q);
      ysz4_q <= (YzW'(ysz_hi_q) <<< SplitW) + YzW'(ysz_lo_q);
      ycz4_q <= (YzW'(ycz_hi_q) <<< SplitW) + YzW'(ycz_lo_q);
      xcy4_q <= xcy3_q;
    end
  end

  // stage 5: x2 = x1*cy + z1*sy, x1 = x << 16
  assign x2_d = (X2W'(xcy4_q) <<< TrigFrac) + X2W'(zsy_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x2_q   <= x2_d;
      ysz5_q <= ysz4_q;
      ycz5_q <= ycz4_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else if (en_i) begin
      v3_q <= valid_i;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  assign valid_o = v5_q;
  assign x2_o    = x2_q;
  assign y1sz_o  = ysz5_q;
  assign y1cz_o  = ycz5_q;

endmodule

### rtl/core/vrp_rot_z.sv
// ----------------------------------------------------------------------------
// vrp_rot_z
// rotation about z, x2 multiplied in three slices
// ----------------------------------------------------------------------------
module vrp_rot_z (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     en_i,
  input  vrp_pkg::cfg_t                            cfg_i,
  input  logic                                     valid_i,
  input  logic signed [vrp_pkg::X2W-1:0]           x2_i,
  input  logic signed [vrp_pkg::YzW-1:0]           y1sz_i,
  input  logic signed [vrp_pkg::YzW-1:0]           y1cz_i,
  output logic                                     valid_o,
  output logic signed [vrp_pkg::FinW-1:0]          x3_o,
  output logic signed [vrp_pkg::FinW-1:0]          y3_o
);
  import vrp_pkg::*;

  logic signed [TrigW-1:0]  sz, cz;
  logic signed [ChunkW:0]   c0, c1;
  logic signed [TopCW-1:0]  c2;

  logic signed [LoP2W-1:0]  p0c_q, p1c_q, p0s_q, p1s_q, p0c7_q, p0s7_q;
  logic signed [HiP2W-1:0]  p2c_q, p2s_q;
  logic signed [MidW-1:0]   midc_q, mids_q;
  logic signed [FinW-1:0]   x2cz_q, x2sz_q, x3_q, y3_q;
  logic signed [YzW-1:0]    ysz6_q, ycz6_q, ysz7_q, ycz7_q, ysz8_q, ycz8_q;
  logic                     v6_q, v7_q, v8_q, v9_q;

  assign sz = $signed(cfg_i.sin_z);
  assign cz = $signed(cfg_i.cos_z);

  assign c0 = {1'b0, x2_i[ChunkW-1:0]};
  assign c1 = {1'b0, x2_i[2*ChunkW-1:ChunkW]};
  assign c2 = x2_i[X2W-1:2*ChunkW];

  // stage 6: slice products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p0c_q  <= c0 * cz;
      p1c_q  <= c1 * cz;
      p2c_q  <= c2 * cz;
      p0s_q  <= c0 * sz;
      p1s_q  <= c1 * sz;
      p2s_q  <= c2 * sz;
      ysz6_q <= y1sz_i;
      ycz6_q <= y1cz_i;
    end
  end

  // stage 7: merge the two upper slices
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      midc_q <= (MidW'(p2c_q) <<< ChunkW) + MidW'(p1c_q);
      mids_q <= (MidW'(p2s_q) <<< ChunkW) + MidW'(p1s_q);
      p0c7_q <= p0c_q;
      p0s7_q <= p0s_q;
      ysz7_q <= ysz6_q;
      ycz7_q <= ycz6_q;
    end
  end

  // stage 8: full x2*cz and x2*sz
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x2cz_q <= (FinW'(midc_q) <<< ChunkW) + FinW'(p0c7_q);
      x2sz_q <= (FinW'(mids_q) <<< ChunkW) + FinW'(p0s7_q);
      ysz8_q <= ysz7_q;
      ycz8_q <= ycz7_q;
    end
  end

  // stage 9: y2 = y1 << 16 enters here
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x3_q <= x2cz_q - (FinW'(ysz8_q) <<< TrigFrac);
      y3_q <= x2sz_q + (FinW'(ycz8_q) <<< TrigFrac);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v6_q <= 1'b0;
      v7_q <= 1'b0;
      v8_q <= 1'b0;
      v9_q <= 1'b0;
    end else if (en_i) begin
      v6_q <= valid_i;
      v7_q <= v6_q;
      v8_q <= v7_q;
      v9_q <= v8_q;
    end
  end

  assign valid_o = v9_q;
  assign x3_o    = x3_q;
  assign y3_o    = y3_q;

endmodule

### rtl/core/vrp_round.sv
// ----------------------------------------------------------------------------
// vrp_round
// screen offset, round half away from zero, saturate to 16 bits
// ----------------------------------------------------------------------------
module vrp_round (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     en_i,
  input  vrp_pkg::cfg_t                            cfg_i,
  input  logic                                     valid_i,
  input  logic signed [vrp_pkg::FinW-1:0]          x3_i,
  input  logic signed [vrp_pkg::FinW-1:0]          y3_i,
  output logic                                     valid_o,
  output vrp_pkg::pix_t                            pix_o
);
  import vrp_pkg::*;

  localparam logic [MagW-1:0] Half = MagW'(1) << (FinalShift - 1);

  logic signed [FinW-1:0] half_w, half_h, px_q, py_q;
  logic [FinW-1:0]        sel_x, sel_y;
  logic [MagW-1:0]        mx_q, my_q;
  logic                   nx_q, ny_q;
  logic [HiW-1:0]         qx, qy;
  logic [ScrW-1:0]        lim_x, lim_y, mag_x, mag_y;
  logic                   clip_x, clip_y;
  pix_t                   pix_d, pix_q;
  logic                   v10_q, v11_q, v12_q;

  // size/2 at scale 2^56
  assign half_w = $signed(FinW'(cfg_i.screen_width) << (FinalShift - 1));
  assign half_h = $signed(FinW'(cfg_i.screen_height) << (FinalShift - 1));

  // stage 10: projection
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      px_q <= half_w + x3_i;
      py_q <= half_h - y3_i;
    end
  end

  // stage 11: magnitude plus half, negation folded into the carry in
  assign sel_x = px_q ^ {FinW{px_q[FinW-1]}};
  assign sel_y = py_q ^ {FinW{py_q[FinW-1]}};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mx_q <= MagW'(sel_x) + MagW'(px_q[FinW-1]) + Half;
      my_q <= MagW'(sel_y) + MagW'(py_q[FinW-1]) + Half;
      nx_q <= px_q[FinW-1];
      ny_q <= py_q[FinW-1];
    end
  end

  // stage 12: saturate and restore sign
  assign qx    = mx_q[MagW-1:FinalShift];
  assign qy    = my_q[MagW-1:FinalShift];
  assign lim_x = nx_q ? ScrMin : ScrMax;
  assign lim_y = ny_q ? ScrMin : ScrMax;

  always_comb begin
    clip_x = qx > HiW'(lim_x);
    clip_y = qy > HiW'(lim_y);
    mag_x  = clip_x ? lim_x : qx[ScrW-1:0];
    mag_y  = clip_y ? lim_y : qy[ScrW-1:0];
    pix_d.screen_x = nx_q ? (~mag_x + ScrW'(1)) : mag_x;
    pix_d.screen_y = ny_q ? (~mag_y + ScrW'(1)) : mag_y;
    pix_d.clipped  = clip_x | clip_y;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pix_q <= pix_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v10_q <= 1'b0;
      v11_q <= 1'b0;
      v12_q <= 1'b0;
    end else if (en_i) begin
      v10_q <= valid_i;
      v11_q <= v10_q;
      v12_q <= v11_q;
    end
  end

  assign valid_o = v12_q;
  assign pix_o   = pix_q;

endmodule

### rtl/core/vertex_rotate_project_unit.sv
// ----------------------------------------------------------------------------
// vertex_rotate_project_unit
// rotates a q15.8 vertex about x, y then z and projects it onto the screen
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake                  payload
//  -------   ---  -------------------------  ------------------------------------
//  vert      in   vert_valid_i/vert_ready_o  vert_x_i, vert_y_i, vert_z_i
//  pix       out  pix_valid_o/pix_ready_i    screen_x_o, screen_y_o, clipped_o
//  cfg       in   cfg_we_i                   cfg_idx_i, cfg_wdata_i
//
//  one vertex beat per cycle while vert_ready_o is high; each result passes
//  12 arithmetic stages (2 for x, 3 for y, 4 for z, 3 for projection/rounding),
//  then the output register; the depth is set by the split multiplies of the
//  wide intermediate terms
//  reset clears all valid bits and loads sines 0, cosines 1.0, 900x700 screen
//  when pix stalls, one more beat lands in a skid register and then the whole
//  pipe freezes; vert_ready_o comes straight from the skid register
//
module vertex_rotate_project_unit (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // configuration writes
  input  logic                                   cfg_we_i,
  input  logic [vrp_pkg::CfgIdxW-1:0]            cfg_idx_i,
  input  logic [vrp_pkg::CfgDataW-1:0]           cfg_wdata_i,
  // vertex beats
  input  logic                                   vert_valid_i,
  output logic                                   vert_ready_o,
  input  logic signed [vrp_pkg::CoordW-1:0]      vert_x_i,
  input  logic signed [vrp_pkg::CoordW-1:0]      vert_y_i,
  input  logic signed [vrp_pkg::CoordW-1:0]      vert_z_i,
  // pixel beats
  output logic                                   pix_valid_o,
  input  logic                                   pix_ready_i,
  output logic signed [vrp_pkg::ScrW-1:0]        screen_x_o,
  output logic signed [vrp_pkg::ScrW-1:0]        screen_y_o,
  output logic                                   clipped_o
);
  import vrp_pkg::*;

  cfg_t cfg_q;

  // pipe advance: frozen only while the skid register holds a beat
  logic en;

  logic                    rx_valid;
  logic signed [RotW-1:0]  y1, z1;
  logic signed [ProdW-1:0] xcy;
  logic                    ry_valid;
  logic signed [X2W-1:0]   x2;
  logic signed [YzW-1:0]   y1sz, y1cz;
  logic                    rz_valid;
  logic signed [FinW-1:0]  x3, y3;
  logic                    rd_valid;
  pix_t                    rd_pix;

  // output register and skid register
  pix_t out_q, skid_q;
  logic out_valid_q, skid_valid_q;
  logic out_free;

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sin_x         <= SinReset;
      cfg_q.cos_x         <= CosReset;
      cfg_q.sin_y         <= SinReset;
      cfg_q.cos_y         <= CosReset;
      cfg_q.sin_z         <= SinReset;
      cfg_q.cos_z         <= CosReset;
      cfg_q.screen_width  <= WidthReset;
      cfg_q.screen_height <= HeightReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgSinX:         cfg_q.sin_x         <= cfg_wdata_i[TrigW-1:0];
        CfgCosX:         cfg_q.cos_x         <= cfg_wdata_i[TrigW-1:0];
        CfgSinY:         cfg_q.sin_y         <= cfg_wdata_i[TrigW-1:0];
        CfgCosY:         cfg_q.cos_y         <= cfg_wdata_i[TrigW-1:0];
        CfgSinZ:         cfg_q.sin_z         <= cfg_wdata_i[TrigW-1:0];
        CfgCosZ:         cfg_q.cos_z         <= cfg_wdata_i[TrigW-1:0];
        CfgScreenWidth:  cfg_q.screen_width  <= cfg_wdata_i[SizeW-1:0];
        CfgScreenHeight: cfg_q.screen_height <= cfg_wdata_i[SizeW-1:0];
        default:         cfg_q <= cfg_q;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // arithmetic pipe
  // ---------------------------------------------------------------------------
  assign en           = !skid_valid_q;
  assign vert_ready_o = en;

  vrp_rot_x u_rot_x (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .cfg_i    (cfg_q),
    .valid_i  (vert_valid_i),
    .vert_x_i (vert_x_i),
    .vert_y_i (vert_y_i),
    .vert_z_i (vert_z_i),
    .valid_o  (rx_valid),
    .y1_o     (y1),
    .z1_o     (z1),
    .xcy_o    (xcy)
  );

  vrp_rot_y u_rot_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .cfg_i   (cfg_q),
    .valid_i (rx_valid),
    .y1_i    (y1),
    .z1_i    (z1),
    .xcy_i   (xcy),
    .valid_o (ry_valid),
    .x2_o    (x2),
    .y1sz_o  (y1sz),
    .y1cz_o  (y1cz)
  );

  vrp_rot_z u_rot_z (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .cfg_i   (cfg_q),
    .valid_i (ry_valid),
    .x2_i    (x2),
    .y1sz_i  (y1sz),
    .y1cz_i  (y1cz),
    .valid_o (rz_valid),
    .x3_o    (x3),
    .y3_o    (y3)
  );

  vrp_round u_round (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .cfg_i   (cfg_q),
    .valid_i (rz_valid),
    .x3_i    (x3),
    .y3_i    (y3),
    .valid_o (rd_valid),
    .pix_o   (rd_pix)
  );

  // ---------------------------------------------------------------------------
  // output register with skid
  // ---------------------------------------------------------------------------
  // the output register can take a beat when empty or being drained
  assign out_free = !out_valid_q || pix_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (out_free) begin
        out_valid_q <= skid_valid_q || (en && rd_valid);
      end
      if (skid_valid_q) begin
        if (out_free) begin
          skid_valid_q <= 1'b0;
        end
      end else if (en && rd_valid && !out_free) begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_q <= skid_valid_q ? skid_q : rd_pix;
    end
    if (!skid_valid_q && !out_free) begin
      skid_q <= rd_pix;
    end
  end

  assign pix_valid_o = out_valid_q;
  assign screen_x_o  = $signed(out_q.screen_x);
  assign screen_y_o  = $signed(out_q.screen_y);
  assign clipped_o   = out_q.clipped;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  // a parked beat always has one in front of it
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid holds a beat while output register is empty");

  // the skid register fills only when the output was stalled
  a_skid_fill_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_valid_q) |-> $past(out_valid_q && !pix_ready_i))
    else $error("skid filled without an output stall");

  // a finished beat leaving the pipe is never dropped
  a_pipe_beat_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && rd_valid) |=> (out_valid_q || skid_valid_q))
    else $error("finished beat lost at the output");

  // clipped means at least one coordinate sits at a limit
  a_clip_at_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.clipped) |->
      (out_q.screen_x == ScrMax || out_q.screen_x == ScrMin ||
       out_q.screen_y == ScrMax || out_q.screen_y == ScrMin))
    else $error("clipped flag set on an unsaturated result");

endmodule

### verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the vertex rotate/project unit
// ----------------------------------------------------------------------------
// vertex beats are queued by the sequence block and sent by a falling-edge
// driver with random gaps; pixel beats are taken with random stalls and each
// one is compared with a pixel worked out from the same vertex and a shadow
// copy of the registers, using exact 128-bit arithmetic at scale 2^56.
// registers are rewritten only while the pipe is empty, through directed
// settings (reset values, trig and size extremes, odd screen sizes) and a
// series of random ones
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import vrp_pkg::*;

  localparam int          VertsPerSet  = 185;      // random vertices per setting
  localparam int          RandomSets   = 10;
  localparam int          DrainCycles  = 24;       // pipe is 13 deep, plus margin
  localparam int          CycleLimit   = 1000000;
  localparam int          MaxReports   = 200;      // keeps the log readable
  localparam logic signed [127:0] RoundHalf = 128'sd1 <<< (FinalShift - 1);

  localparam logic signed [CoordW-1:0] CoordMax = 24'sh7fffff;
  localparam logic signed [CoordW-1:0] CoordMin = 24'sh800000;
  localparam logic signed [CoordW-1:0] HalfPix  = 24'sh000080;   // 0.5 in q15.8

  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] z;
  } vertex_t;

  // dut ports
  logic                     clk_i;
  logic                     rst_ni;
  logic                     cfg_we_i;
  logic [CfgIdxW-1:0]       cfg_idx_i;
  logic [CfgDataW-1:0]      cfg_wdata_i;
  logic                     vert_valid_i;
  logic                     vert_ready_o;
  logic signed [CoordW-1:0] vert_x_i;
  logic signed [CoordW-1:0] vert_y_i;
  logic signed [CoordW-1:0] vert_z_i;
  logic                     pix_valid_o;
  logic                     pix_ready_i;
  logic signed [ScrW-1:0]   screen_x_o;
  logic signed [ScrW-1:0]   screen_y_o;
  logic                     clipped_o;

  // bench state
  vertex_t             vert_pending[$];    // vertices not yet offered
  pix_t                pix_expect[$];      // pixels owed by the unit, oldest first
  cfg_t                cfg_shadow;         // what the registers hold now
  logic [CfgDataW-1:0] reg_vals [8];       // next register setting, by index
  int                  vert_sent_cnt = 0;
  int                  vert_acc_cnt  = 0;
  int                  pix_cnt       = 0;
  int                  clip_cnt      = 0;
  int                  err_cnt       = 0;
  int                  cfg_sets      = 0;
  int                  cycle_cnt     = 0;
  int                  vert_gap      = 0;
  int                  pix_stall     = 0;
  logic                vert_idle_en  = 1'b0;
  logic                pix_idle_en   = 1'b0;

  vertex_rotate_project_unit u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .vert_valid_i (vert_valid_i),
    .vert_ready_o (vert_ready_o),
    .vert_x_i     (vert_x_i),
    .vert_y_i     (vert_y_i),
    .vert_z_i     (vert_z_i),
    .pix_valid_o  (pix_valid_o),
    .pix_ready_i  (pix_ready_i),
    .screen_x_o   (screen_x_o),
    .screen_y_o   (screen_y_o),
    .clipped_o    (clipped_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // pixel prediction
  // ---------------------------------------------------------------------------

  // scale 2^56 value -> integer, half away from zero, saturated; top bit = clipped
  function automatic logic [ScrW:0] round_sat(logic signed [127:0] v);
    logic signed [127:0] mag;
    logic signed [127:0] q;
    logic signed [127:0] limit;
    logic                neg;
    logic                sat;
    neg   = v < 0;
    mag   = neg ? -v : v;
    q     = (mag + RoundHalf) >>> FinalShift;
    limit = neg ? 128'sd32768 : 128'sd32767;
    sat   = q > limit;
    if (sat) q = limit;
    if (neg) q = -q;
    return {sat, q[ScrW-1:0]};
  endfunction

  // rotate x, then y, then z, then place on the screen; no rounding before the end
  function automatic pix_t project_vertex(vertex_t v);
    logic signed [127:0] x, y, z;
    logic signed [127:0] sx, cx, sy, cy, sz, cz;
    logic signed [127:0] x1, y1, z1, x2, y2, x3, y3;
    logic signed [127:0] wd, ht;
    logic [ScrW:0]       rx, ry;
    pix_t                p;
    x  = v.x;
    y  = v.y;
    z  = v.z;
    sx = $signed(cfg_shadow.sin_x);
    cx = $signed(cfg_shadow.cos_x);
    sy = $signed(cfg_shadow.sin_y);
    cy = $signed(cfg_shadow.cos_y);
    sz = $signed(cfg_shadow.sin_z);
    cz = $signed(cfg_shadow.cos_z);
    wd = cfg_shadow.screen_width;
    ht = cfg_shadow.screen_height;
    // about x, scale 2^24
    y1 = y * cx - z * sx;
    z1 = y * sx + z * cx;
    x1 = x <<< TrigFrac;
    // about y, scale 2^40
    x2 = x1 * cy + z1 * sy;
    y2 = y1 <<< TrigFrac;
    // about z, scale 2^56
    x3 = x2 * cz - y2 * sz;
    y3 = x2 * sz + y2 * cz;
    // half of the screen size is size << 55, odd sizes stay exact
    rx = round_sat((wd <<< (FinalShift - 1)) + x3);
    ry = round_sat((ht <<< (FinalShift - 1)) - y3);
    p.screen_x = rx[ScrW-1:0];
    p.screen_y = ry[ScrW-1:0];
    p.clipped  = rx[ScrW] | ry[ScrW];
    return p;
  endfunction

  // ---------------------------------------------------------------------------
  // random values
  // ---------------------------------------------------------------------------

  // mostly no gap, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return 0;
    if (r < 93) return $urandom_range(1, 3);
    if (r < 99) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [CoordW-1:0] rand_coord();
    int r;
    int v;
    r = $urandom_range(0, 99);
    if (r < 45) begin
      // within about a thousand pixels, where little saturates
      v = int'($urandom_range(0, 524288)) - 262144;
    end else if (r < 80) begin
      v = $urandom;
    end else if (r < 90) begin
      case ($urandom_range(0, 4))
        0:       v = CoordMax;
        1:       v = CoordMin;
        2:       v = 0;
        3:       v = -1;
        default: v = 1;
      endcase
    end else begin
      // exactly half a pixel off the grid
      v = (int'($urandom_range(0, 4000)) - 2000) * 256 + (($urandom_range(0, 1) != 0) ? 128 : -128);
    end
    return v[CoordW-1:0];
  endfunction

  function automatic logic [TrigW-1:0] rand_trig();
    int r;
    int v;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      v = int'($urandom_range(0, 131072)) - 65536;
    end else if (r < 85) begin
      case ($urandom_range(0, 4))
        0:       v = -131072;
        1:       v = 131071;
        2:       v = 65536;
        3:       v = -65536;
        default: v = 0;
      endcase
    end else begin
      v = $urandom;
    end
    return v[TrigW-1:0];
  endfunction

  function automatic logic [SizeW-1:0] rand_size();
    int r;
    int v;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      v = $urandom_range(1, 4096);
    end else if (r < 80) begin
      case ($urandom_range(0, 4))
        0:       v = 0;
        1:       v = 1;
        2:       v = 4095;
        3:       v = 4096;
        default: v = 8191;
      endcase
    end else begin
      v = $urandom_range(0, 8191);
    end
    return v[SizeW-1:0];
  endfunction

  // ---------------------------------------------------------------------------
  // sequence helpers
  // ---------------------------------------------------------------------------

  task automatic push_vertex(logic signed [CoordW-1:0] x, logic signed [CoordW-1:0] y,
                             logic signed [CoordW-1:0] z);
    vertex_t v;
    v.x = x;
    v.y = y;
    v.z = z;
    vert_pending.insert(vert_pending.size(), v);
  endtask

  // one write per cycle, we held high across the whole burst
  task automatic write_all_regs();
    cfg_idx_e idx;
    for (int i = 0; i < 8; i++) begin
      idx = cfg_idx_e'(i);
      @(negedge clk_i);
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= idx;
      cfg_wdata_i <= reg_vals[i];
      @(posedge clk_i);
      case (idx)
        CfgSinX:         cfg_shadow.sin_x         = reg_vals[i];
        CfgCosX:         cfg_shadow.cos_x         = reg_vals[i];
        CfgSinY:         cfg_shadow.sin_y         = reg_vals[i];
        CfgCosY:         cfg_shadow.cos_y         = reg_vals[i];
        CfgSinZ:         cfg_shadow.sin_z         = reg_vals[i];
        CfgCosZ:         cfg_shadow.cos_z         = reg_vals[i];
        CfgScreenWidth:  cfg_shadow.screen_width  = reg_vals[i][SizeW-1:0];
        CfgScreenHeight: cfg_shadow.screen_height = reg_vals[i][SizeW-1:0];
        default: ;
      endcase
    end
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    cfg_sets++;
  endtask

  // same angle pattern on all three axes
  task automatic set_uniform(logic [TrigW-1:0] s, logic [TrigW-1:0] c,
                             logic [SizeW-1:0] w, logic [SizeW-1:0] h);
    reg_vals[CfgSinX]         = s;
    reg_vals[CfgCosX]         = c;
    reg_vals[CfgSinY]         = s;
    reg_vals[CfgCosY]         = c;
    reg_vals[CfgSinZ]         = s;
    reg_vals[CfgCosZ]         = c;
    reg_vals[CfgScreenWidth]  = CfgDataW'(w);
    reg_vals[CfgScreenHeight] = CfgDataW'(h);
    write_all_regs();
  endtask

  // all vertices out, all pixels back, then let the pipe settle
  task automatic wait_drain();
    while (vert_pending.size() != 0 || vert_sent_cnt != vert_acc_cnt ||
           pix_expect.size() != 0)
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // vertex driver: falling edge, holds the beat until it is taken
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    vertex_t v;
    if (vert_sent_cnt == vert_acc_cnt) begin
      if (vert_gap > 0) begin
        vert_gap--;
        vert_valid_i <= 1'b0;
      end else if (vert_pending.size() != 0) begin
        v = vert_pending.pop_front();
        vert_x_i     <= v.x;
        vert_y_i     <= v.y;
        vert_z_i     <= v.z;
        vert_valid_i <= 1'b1;
        vert_sent_cnt++;
        vert_gap = vert_idle_en ? pick_gap() : 0;
      end else begin
        vert_valid_i <= 1'b0;
      end
    end
  end

  // pixel back-pressure
  always @(negedge clk_i) begin
    if (pix_stall > 0) begin
      pix_stall--;
      pix_ready_i <= 1'b0;
    end else begin
      pix_ready_i <= 1'b1;
      pix_stall = pix_idle_en ? pick_gap() : 0;
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: rising edge, checks pixel beats and predicts from vertex beats
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    pix_t    want;
    vertex_t v;
    // check the outgoing beat first so a beat taken this edge cannot match itself
    if (pix_valid_o && pix_ready_i) begin
      pix_cnt++;
      if (clipped_o) clip_cnt++;
      if (pix_expect.size() == 0) begin
        err_cnt++;
        if (err_cnt <= MaxReports)
          $display("%0t: pixel beat with no vertex outstanding, expected none, got x %0d y %0d c %0b",
                   $time, screen_x_o, screen_y_o, clipped_o);
      end else begin
        want = pix_expect.pop_front();
        if (want.screen_x !== screen_x_o) begin
          err_cnt++;
          if (err_cnt <= MaxReports)
            $display("%0t: screen_x expected %0d got %0d", $time,
                     $signed(want.screen_x), screen_x_o);
        end
        if (want.screen_y !== screen_y_o) begin
          err_cnt++;
          if (err_cnt <= MaxReports)
            $display("%0t: screen_y expected %0d got %0d", $time,
                     $signed(want.screen_y), screen_y_o);
        end
        if (want.clipped !== clipped_o) begin
          err_cnt++;
          if (err_cnt <= MaxReports)
            $display("%0t: clipped expected %0b got %0b", $time, want.clipped, clipped_o);
        end
      end
    end
    if (vert_valid_i && vert_ready_o) begin
      v.x = vert_x_i;
      v.y = vert_y_i;
      v.z = vert_z_i;
      pix_expect.insert(pix_expect.size(), project_vertex(v));
      vert_acc_cnt++;
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("%0t: no progress, %0d pixels still owed", $time, pix_expect.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = CfgSinX;
    cfg_wdata_i  = '0;
    vert_valid_i = 1'b0;
    vert_x_i     = '0;
    vert_y_i     = '0;
    vert_z_i     = '0;
    pix_ready_i  = 1'b0;
    cfg_shadow   = '{SinReset, CosReset, SinReset, CosReset, SinReset, CosReset,
                     WidthReset, HeightReset};
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset setting: identity rotation on 900x700
    push_vertex(0, 0, 0);
    push_vertex(CoordMax, 0, 0);               // right edge saturates
    push_vertex(CoordMin, 0, 0);
    push_vertex(0, CoordMax, 0);
    push_vertex(0, CoordMin, 0);               // flipped y saturates
    push_vertex(0, 0, CoordMax);               // z has no effect here
    push_vertex(0, 0, CoordMin);
    push_vertex(HalfPix, HalfPix, 0);          // exact halves round away from zero
    push_vertex(-HalfPix, -HalfPix, 0);
    wait_drain();

    // trig at the 18-bit extremes, zero-size screen
    set_uniform(18'h20000, 18'h1ffff, 13'd0, 13'd0);
    push_vertex(0, 0, 0);
    push_vertex(CoordMax, CoordMax, CoordMax);
    push_vertex(CoordMin, CoordMin, CoordMin);
    push_vertex(CoordMax, CoordMin, CoordMax);
    push_vertex(HalfPix, 0, 0);
    push_vertex(0, 0, -HalfPix);
    wait_drain();

    // identity again, odd sizes put the center on a half pixel
    set_uniform(SinReset, CosReset, 13'd1, 13'd8191);
    push_vertex(0, 0, 0);
    push_vertex(-HalfPix, 0, 0);
    push_vertex(-(HalfPix + HalfPix), 0, 0);
    push_vertex(CoordMin, 0, 0);               // lands on -32768 without clipping
    push_vertex(0, HalfPix + HalfPix + HalfPix, 0);
    push_vertex(0, -HalfPix, 0);
    wait_drain();

    // random settings; idling off, sender only, receiver only, both
    for (int s = 0; s < RandomSets; s++) begin
      vert_idle_en = s[0];
      pix_idle_en  = s[1];
      for (int i = 0; i < 6; i++) reg_vals[i] = rand_trig();
      reg_vals[CfgScreenWidth]  = CfgDataW'(rand_size());
      reg_vals[CfgScreenHeight] = CfgDataW'(rand_size());
      write_all_regs();
      for (int n = 0; n < VertsPerSet; n++)
        push_vertex(rand_coord(), rand_coord(), rand_coord());
      wait_drain();
    end

    $display("covered %0d vertices under %0d register settings plus reset values",
             vert_acc_cnt, cfg_sets);
    $display("checked %0d pixels, %0d of them saturated, %0d mismatches",
             pix_cnt, clip_cnt, err_cnt);
    if (err_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
